>>> hw/rtl/ewph_pkg.sv
// Package for the event word parser and histogrammer.
// Holds the shared codes, field widths and the queue item type.
// Used by every module of the block.
package ewph_pkg;

   localparam int WORD_W      = 32;
   localparam int BIN_INDEX_W = 18;
   localparam int RES_W       = 14;
   localparam int MODULE_W    = 8;
   localparam int CHANNEL_W   = 5;
   localparam int AMP_W       = 13;
   localparam int WORDS_W     = 10;
   localparam int BIN_COUNT_W = 32;

   typedef enum logic [2:0] {
      KIND_HEADER    = 3'd0,
      KIND_COUNTED   = 3'd1,
      KIND_UNCOUNTED = 3'd2,
      KIND_TERM      = 3'd3,
      KIND_READOUT   = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_DATA   = 2'd1,
      PH_TERM   = 2'd2
   } phase_type;

   typedef struct packed {
      kind_type                 kind;
      logic                     header_error;
      logic                     range_error;
      logic [MODULE_W-1:0]      module_number;
      logic [CHANNEL_W-1:0]     channel_number;
      logic [AMP_W-1:0]         amplitude;
      logic [WORDS_W-1:0]       words_left;
      logic [BIN_INDEX_W-1:0]   bin_addr;
      logic                     out_of_range;
   } op_type;

endpackage

>>> hw/rtl/event_word_parser_histogrammer.sv
// Top level of the event word parser and histogrammer.
// Path: an accepted item passes the queue, the stage-one register and the rsp register.
// Throughput: one item per cycle unless rsp_tready or the clearing sweep holds the flow;
// the histogram read-modify-write forwards the last write and is fed by a two-entry queue.
// Reset: synchronous; then a clearing sweep zeroes all CHANNELS*MAX_RESOLUTION bins
// (262144 by default) of the histogram while req_tready stays low.
module event_word_parser_histogrammer import ewph_pkg::*; #(
   parameter int CHANNELS       = 32,
   parameter int MAX_RESOLUTION = 8192,
   parameter int COUNT_WIDTH    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // word[31:0], bin_index[49:32], zero fill
   input  logic [0:0]  req_tuser,   // action[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // module_number[7:0], channel_number[12:8],
                                    // amplitude[25:13], bin_count[57:26],
                                    // words_left[67:58], zero fill
   output logic [4:0]  rsp_tuser,   // word_kind[2:0], header_error[3], range_error[4]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [13:0] csr_data     // resolution
);

   logic                   accept;
   logic                   q_full;
   logic                   q_pop;
   logic                   q_valid;
   logic                   clear_busy;
   op_type                 front_op;
   op_type                 head_op;
   op_type                 rsp_op;
   logic [BIN_COUNT_W-1:0] rsp_count;

   assign req_tready = !q_full && !clear_busy;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   ewph_parser #(
      .CHANNELS       (CHANNELS),
      .MAX_RESOLUTION (MAX_RESOLUTION)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .action    (req_tuser[0]),
      .word      (req_tdata[31:0]),
      .bin_index (req_tdata[49:32]),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .op        (front_op)
   );

   ewph_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_op    (front_op),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_op    (head_op)
   );

   ewph_hist #(
      .CHANNELS       (CHANNELS),
      .MAX_RESOLUTION (MAX_RESOLUTION),
      .COUNT_WIDTH    (COUNT_WIDTH)
   ) u_hist (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head_op    (head_op),
      .pop        (q_pop),
      .clear_busy (clear_busy),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_op     (rsp_op),
      .rsp_count  (rsp_count)
   );

   assign rsp_tdata = {4'b0, rsp_op.words_left, rsp_count, rsp_op.amplitude,
                       rsp_op.channel_number, rsp_op.module_number};
   assign rsp_tuser = {rsp_op.range_error, rsp_op.header_error, rsp_op.kind};

endmodule

>>> hw/rtl/ewph_parser.sv
// Front end: parses stream words, tracks event state, computes bin addresses.
// Holds the resolution register. Depends on ewph_pkg.
module ewph_parser import ewph_pkg::*; #(
   parameter int CHANNELS       = 32,
   parameter int MAX_RESOLUTION = 8192
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   action,
   input  logic [WORD_W-1:0]      word,
   input  logic [BIN_INDEX_W-1:0] bin_index,
   input  logic                   csr_valid,
   input  logic [RES_W-1:0]       csr_data,
   output op_type                 op
);

   localparam int NBINS = CHANNELS * MAX_RESOLUTION;

   phase_type               phase_ff, phase_in;
   logic [WORDS_W-1:0]      remaining_ff, remaining_in;
   logic [MODULE_W-1:0]     module_ff, module_in;
   logic [RES_W-1:0]        resolution_ff;
   logic [RES_W-1:0]        res_eff;
   logic [CHANNEL_W-1:0]    ch;
   logic [AMP_W-1:0]        amp;
   logic                    match;
   logic                    bad;
   logic [BIN_INDEX_W:0]    idx;
   logic [WORDS_W-1:0]      hdr_count;

   assign res_eff = (resolution_ff > RES_W'(MAX_RESOLUTION)) ?
                    RES_W'(MAX_RESOLUTION) : resolution_ff;
   assign ch    = word[20:16];
   assign amp   = word[12:0];
   assign match = (word[31:28] == 4'b0001) || (word[31:23] == 9'b000001000);
   assign bad   = ({1'b0, amp} >= res_eff) ||
                  ({1'b0, ch} >= (CHANNEL_W+1)'(CHANNELS));
   assign idx   = (BIN_INDEX_W+1)'(ch) * (BIN_INDEX_W+1)'(res_eff) +
                  (BIN_INDEX_W+1)'(amp);
   assign hdr_count = word[9:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         remaining_ff  <= '0;
         module_ff     <= '0;
         resolution_ff <= RES_W'(8192);
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            remaining_ff <= remaining_in;
            module_ff    <= module_in;
         end
         if (csr_valid) begin
            resolution_ff <= csr_data;
         end
      end
   end

   always_comb begin
      logic do_header;
      logic do_data;
      do_header    = 1'b0;
      do_data      = 1'b0;
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      module_in    = module_ff;
      op           = '0;
      if (action) begin
         op.kind         = KIND_READOUT;
         op.bin_addr     = bin_index;
         op.out_of_range = ({1'b0, bin_index} >= (BIN_INDEX_W+1)'(NBINS));
      end else begin
         case (phase_ff)
            PH_DATA: begin
               if (remaining_ff != '0) begin
                  do_data = 1'b1;
               end else begin
                  do_header = 1'b1;
               end
            end
            PH_TERM: begin
               if (word[31:30] == 2'b11) begin
                  op.kind  = KIND_TERM;
                  phase_in = PH_HEADER;
               end else begin
                  do_header = 1'b1;
               end
            end
            default: begin
               do_header = 1'b1;
            end
         endcase
      end
      if (do_data) begin
         op.kind           = (match && !bad) ? KIND_COUNTED : KIND_UNCOUNTED;
         op.range_error    = bad;
         op.channel_number = ch;
         op.amplitude      = amp;
         op.bin_addr       = idx[BIN_INDEX_W-1:0];
         remaining_in      = remaining_ff - 1'b1;
         if (remaining_in == '0) begin
            phase_in = PH_TERM;
         end
      end
      if (do_header) begin
         op.kind         = KIND_HEADER;
         op.header_error = (word[31:30] != 2'b01);
         module_in       = word[23:16];
         remaining_in    = (hdr_count > WORDS_W'(1)) ? hdr_count - 1'b1 : '0;
         phase_in        = (remaining_in != '0) ? PH_DATA : PH_TERM;
      end
      op.module_number = module_in;
      op.words_left    = remaining_in;
   end

   a_term_to_header: assert property (@(posedge clock) disable iff (reset)
      (accept && op.kind == KIND_TERM) |=> (phase_ff == PH_HEADER))
      else $error("terminator did not return parser to header phase");

   a_data_has_words: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (remaining_ff != '0))
      else $error("data phase with no words left");

   a_counted_in_range: assert property (@(posedge clock) disable iff (reset)
      (accept && op.kind == KIND_COUNTED) |->
         ({1'b0, op.bin_addr} < (BIN_INDEX_W+1)'(NBINS)))
      else $error("counted word maps outside the histogram");

endmodule

>>> hw/rtl/ewph_queue.sv
// Two-entry queue between the parser and the histogram engine.
// Depends on ewph_pkg for the item type.
module ewph_queue import ewph_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   output logic   full,
   input  logic   pop,
   output logic   head_valid,
   output op_type head_op
);

   op_type      entry_ff [2];
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic [1:0]  count_ff;
   logic [1:0]  count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_op    = entry_ff[rd_ptr_ff];
   assign count_in   = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head_valid))
      else $error("pop from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

endmodule

>>> hw/rtl/ewph_hist.sv
// Back end: histogram memory with read-modify-write, forwarding and output register.
// Runs the clearing sweep after reset. Depends on ewph_pkg.
module ewph_hist import ewph_pkg::*; #(
   parameter int CHANNELS       = 32,
   parameter int MAX_RESOLUTION = 8192,
   parameter int COUNT_WIDTH    = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  op_type                 head_op,
   output logic                   pop,
   output logic                   clear_busy,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output op_type                 rsp_op,
   output logic [BIN_COUNT_W-1:0] rsp_count
);

   localparam int NBINS = CHANNELS * MAX_RESOLUTION;
   localparam int AW    = (NBINS > 1) ? $clog2(NBINS) : 1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic [COUNT_WIDTH-1:0] mem [NBINS];
   logic [COUNT_WIDTH-1:0] rd_data_ff;
   logic                   clear_busy_ff;
   logic [AW-1:0]          clear_addr_ff;
   op_type                 s1_ff;
   logic                   s1_valid_ff;
   logic                   s1_go;
   logic                   out_free;
   op_type                 out_ff;
   logic [BIN_COUNT_W-1:0] out_count_ff;
   logic                   out_valid_ff;
   logic                   fwd_valid_ff;
   logic [AW-1:0]          fwd_addr_ff;
   logic [COUNT_WIDTH-1:0] fwd_data_ff;
   logic [AW-1:0]          s1_addr;
   logic [COUNT_WIDTH-1:0] cur_count;
   logic [COUNT_WIDTH-1:0] new_count;
   logic [COUNT_WIDTH-1:0] res_count;
   logic [COUNT_WIDTH+BIN_COUNT_W-1:0] count_ext;
   logic                   s1_counted;
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [COUNT_WIDTH-1:0] mem_wdata;

   assign out_free   = !out_valid_ff || rsp_ready;
   assign s1_go      = s1_valid_ff && out_free;
   assign pop        = head_valid && !clear_busy_ff && (!s1_valid_ff || s1_go);
   assign clear_busy = clear_busy_ff;

   assign s1_addr    = s1_ff.bin_addr[AW-1:0];
   assign s1_counted = (s1_ff.kind == KIND_COUNTED);
   assign cur_count  = (fwd_valid_ff && fwd_addr_ff == s1_addr) ? fwd_data_ff : rd_data_ff;
   assign new_count  = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;

   always_comb begin
      case (s1_ff.kind)
         KIND_COUNTED: res_count = new_count;
         KIND_READOUT: res_count = s1_ff.out_of_range ? '0 : cur_count;
         default:      res_count = '0;
      endcase
   end

   assign count_ext = {{BIN_COUNT_W{1'b0}}, res_count};

   assign mem_we    = clear_busy_ff || (s1_go && s1_counted);
   assign mem_waddr = clear_busy_ff ? clear_addr_ff : s1_addr;
   assign mem_wdata = clear_busy_ff ? '0 : new_count;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (pop) begin
         rd_data_ff <= mem[head_op.bin_addr[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         fwd_valid_ff  <= 1'b0;
      end else begin
         if (clear_busy_ff) begin
            clear_addr_ff <= clear_addr_ff + 1'b1;
            if (clear_addr_ff == AW'(NBINS - 1)) begin
               clear_busy_ff <= 1'b0;
            end
         end
         if (pop) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_go) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (s1_go && s1_counted) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_ff <= head_op;
      end
      if (s1_go) begin
         out_ff       <= s1_ff;
         out_count_ff <= count_ext[BIN_COUNT_W-1:0];
      end
      if (s1_go && s1_counted) begin
         fwd_addr_ff <= s1_addr;
         fwd_data_ff <= new_count;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_op    = out_ff;
   assign rsp_count = out_count_ff;

   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy_ff |-> (!pop && !s1_valid_ff))
      else $error("item issued during clearing sweep");

   a_counted_nonzero: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_counted) |-> (new_count != '0))
      else $error("counted bin has zero count");

   a_s1_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> (s1_valid_ff && $stable(rd_data_ff)))
      else $error("stalled stage lost its read data");

endmodule
